[hdl/pam_pkg.sv]
// Package for the timestamp address matcher: payload structs, window node type,
// queue control struct and the command, status and register index codes.
// No dependencies.
package pam_pkg;

   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_FETCH = 2'd1;
   localparam logic [1:0] CMD_DROP  = 2'd2;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FOUND   = 2'd1;
   localparam logic [1:0] ST_NONE    = 2'd2;
   localparam logic [1:0] ST_REFUSED = 2'd3;

   localparam logic [1:0] REG_STREAM_BASE = 2'd0;
   localparam logic [1:0] REG_STREAM_SIZE = 2'd1;
   localparam logic [1:0] REG_WRAP_LIMIT  = 2'd2;

   localparam int ADDR_BITS = 28;
   localparam int WRAP_BITS = 10;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] node_address;
      logic [31:0] node_stamp;
      logic [31:0] query_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] stamp;
   } rsp_type;

   typedef struct packed {
      logic [31:0]          addr;
      logic [31:0]          stamp;
      logic [WRAP_BITS-1:0] wraps;
      logic                 used;
   } win_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

endpackage

[hdl/pam_node_queue.sv]
// Node queue of the timestamp address matcher: a circular buffer memory with
// head, tail and fill count, and a registered read of the head entry. Uses pam_pkg.
module pam_node_queue #(
   parameter int DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pam_pkg::queue_ctl_type ctl,
   input  logic [63:0]            push_data,
   output logic [63:0]            head_data,
   output logic                   empty,
   output logic                   full
);
   import pam_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(DEPTH);

   logic [63:0]         mem [DEPTH];
   logic [PTR_BITS-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [63:0]         rd_ff;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == FULL_CNT);
   assign head_data = rd_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      if (ctl.pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= push_data;
      end
      rd_ff <= mem[head_ff];
   end

endmodule

[hdl/pts_address_matcher_top.sv]
// Top level of the timestamp address matcher: sequencer, window nodes, wrap
// counters and the shared absolute-address unit. Uses pam_pkg and pam_node_queue.
//
// Usage: one item is taken on the req_ channel when req_valid and req_ready are
// both high, and exactly one result leaves on the rsp_ channel. A push queues a
// rebased address and timestamp; a fetch or drop matches a stream address against
// the current and next window nodes, popping queued nodes as needed.
// Only one item is in flight: req_ready is high only while the sequencer is idle.
// A push or an unknown command goes from decode straight to the output state. A
// fetch or drop first loads a node from the queue if none is held, then runs
// comparison passes; the shared multiply-add unit, used three times per pass,
// forms the stream, current and next absolute addresses, and a pass may pop
// another node and run again.
// A finished result sits in the output register; the next item is accepted while
// it waits, and the sequencer holds its next result until rsp_ready takes the
// earlier one. Reset is synchronous and clears all control state and the
// configuration to its defaults. The csr_ port writes a configuration register and
// must only be used while the block is idle.
module pts_address_matcher_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pam_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pam_pkg::rsp_type rsp_payload,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [27:0]      csr_write_data
);
   import pam_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_POP_WAIT = 4'd2;
   localparam logic [3:0] S_POP_USE  = 4'd3;
   localparam logic [3:0] S_TRACK    = 4'd4;
   localparam logic [3:0] S_MUL_F    = 4'd5;
   localparam logic [3:0] S_MUL_C    = 4'd6;
   localparam logic [3:0] S_MUL_N    = 4'd7;
   localparam logic [3:0] S_DECIDE   = 4'd8;
   localparam logic [3:0] S_OUT      = 4'd9;

   logic [3:0]           state_ff, state_in;
   req_type              item_ff, item_in;
   rsp_type              res_ff, res_in, rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   win_type              cur_ff, cur_in, nxt_ff, nxt_in;
   logic                 have_first_ff, have_first_in;
   logic [WRAP_BITS-1:0] stream_wraps_ff, stream_wraps_in;
   logic [WRAP_BITS-1:0] node_wraps_ff, node_wraps_in;
   logic [31:0]          prev_query_ff, prev_query_in;
   logic [31:0]          prev_node_ff, prev_node_in;
   logic [31:0]          af_ff, af_in, ac_ff, ac_in, an_ff, an_in;
   logic [ADDR_BITS-1:0] base_ff, size_ff;
   logic [WRAP_BITS-1:0] limit_ff;

   queue_ctl_type        q_ctl;
   logic [63:0]          q_head;
   logic                 q_empty, q_full;

   logic [31:0]          mul_addr, mul_sum;
   logic [WRAP_BITS-1:0] mul_wraps;
   logic [37:0]          mul_prod;

   pam_node_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (q_ctl),
      .push_data ({{4'd0, item_ff.node_address[27:0]} - {4'd0, base_ff},
                   item_ff.node_stamp}),
      .head_data (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Shared multiply-add unit: address plus wrap count times buffer size.
   always_comb begin
      unique case (state_ff)
         S_MUL_C: begin
            mul_addr  = cur_ff.addr;
            mul_wraps = cur_ff.wraps;
         end
         S_MUL_N: begin
            mul_addr  = nxt_ff.addr;
            mul_wraps = nxt_ff.wraps;
         end
         default: begin
            mul_addr  = item_ff.query_address;
            mul_wraps = stream_wraps_ff;
         end
      endcase
      mul_prod = 38'(mul_wraps) * 38'(size_ff);
      mul_sum  = mul_addr + mul_prod[31:0];
   end

   always_comb begin
      logic [WRAP_BITS-1:0] nw, sw;
      win_type              fresh;
      state_in        = state_ff;
      item_in         = item_ff;
      res_in          = res_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      cur_in          = cur_ff;
      nxt_in          = nxt_ff;
      have_first_in   = have_first_ff;
      stream_wraps_in = stream_wraps_ff;
      node_wraps_in   = node_wraps_ff;
      prev_query_in   = prev_query_ff;
      prev_node_in    = prev_node_ff;
      af_in           = af_ff;
      ac_in           = ac_ff;
      an_in           = an_ff;
      q_ctl           = '0;
      nw              = node_wraps_ff;
      sw              = stream_wraps_ff;
      fresh.addr      = q_head[63:32];
      fresh.stamp     = q_head[31:0];
      fresh.wraps     = '0;
      fresh.used      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_payload;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in   = '{status: ST_DONE, stamp: 32'd0};
            state_in = S_OUT;
            if (item_ff.command == CMD_PUSH) begin
               if (q_full) begin
                  res_in.status = ST_REFUSED;
               end else begin
                  q_ctl.push = 1'b1;
               end
            end else if (item_ff.command == CMD_FETCH || item_ff.command == CMD_DROP) begin
               if (item_ff.command == CMD_FETCH) begin
                  res_in.status = ST_NONE;
               end
               if (have_first_ff) begin
                  state_in = S_TRACK;
               end else if (!q_empty) begin
                  state_in = S_POP_WAIT;
               end
            end
         end
         S_POP_WAIT: begin
            // The registered head read settles during this cycle.
            state_in = S_POP_USE;
         end
         S_POP_USE: begin
            q_ctl.pop    = 1'b1;
            prev_node_in = fresh.addr;
            if (!have_first_ff) begin
               cur_in        = fresh;
               nxt_in        = fresh;
               have_first_in = 1'b1;
               state_in      = S_TRACK;
            end else begin
               cur_in = nxt_ff;
               if (fresh.addr < prev_node_ff) begin
                  nw = node_wraps_ff + 1'b1;
                  if (nw == limit_ff) begin
                     stream_wraps_in = '0;
                     cur_in.wraps    = '0;
                     nw              = WRAP_BITS'(1);
                  end
               end
               node_wraps_in = nw;
               fresh.wraps   = nw;
               nxt_in        = fresh;
               state_in      = S_MUL_F;
            end
         end
         S_TRACK: begin
            if (item_ff.query_address < prev_query_ff) begin
               sw = stream_wraps_ff + 1'b1;
               if (sw == limit_ff) begin
                  node_wraps_in = '0;
                  cur_in.wraps  = '0;
                  nxt_in.wraps  = '0;
                  sw            = WRAP_BITS'(1);
               end
            end
            stream_wraps_in = sw;
            prev_query_in   = item_ff.query_address;
            state_in        = S_MUL_F;
         end
         S_MUL_F: begin
            af_in    = mul_sum;
            state_in = S_MUL_C;
         end
         S_MUL_C: begin
            ac_in    = mul_sum;
            state_in = S_MUL_N;
         end
         S_MUL_N: begin
            an_in    = mul_sum;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_OUT;
            if (item_ff.command == CMD_FETCH) begin
               if (af_ff < ac_ff) begin
                  state_in = S_OUT;
               end else if (af_ff < an_ff) begin
                  if (!cur_ff.used) begin
                     cur_in.used = 1'b1;
                     res_in      = '{status: ST_FOUND, stamp: cur_ff.stamp};
                  end
               end else if (!q_empty) begin
                  state_in = S_POP_WAIT;
               end else if (!nxt_ff.used) begin
                  nxt_in.used = 1'b1;
                  res_in      = '{status: ST_FOUND, stamp: nxt_ff.stamp};
               end
            end else if (af_ff > an_ff && !q_empty) begin
               state_in = S_POP_WAIT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         cur_ff          <= '0;
         nxt_ff          <= '0;
         have_first_ff   <= 1'b0;
         stream_wraps_ff <= '0;
         node_wraps_ff   <= '0;
         prev_query_ff   <= '0;
         prev_node_ff    <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         cur_ff          <= cur_in;
         nxt_ff          <= nxt_in;
         have_first_ff   <= have_first_in;
         stream_wraps_ff <= stream_wraps_in;
         node_wraps_ff   <= node_wraps_in;
         prev_query_ff   <= prev_query_in;
         prev_node_ff    <= prev_node_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      af_ff   <= af_in;
      ac_ff   <= ac_in;
      an_ff   <= an_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         size_ff  <= ADDR_BITS'(1048576);
         limit_ff <= WRAP_BITS'(500);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_STREAM_BASE: base_ff  <= csr_write_data;
            REG_STREAM_SIZE: size_ff  <= csr_write_data;
            REG_WRAP_LIMIT:  limit_ff <= csr_write_data[WRAP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in flight");

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue reports full and empty together");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_ctl.pop |-> !q_empty)
      else $error("pop from an empty queue");

   a_first_node_sticks: assert property (@(posedge clock) disable iff (reset)
      have_first_ff |=> have_first_ff)
      else $error("first node flag dropped");

endmodule
